@@ sv/dq_pkg.sv @@
package dq_pkg;

   // request kind codes
   localparam logic [2:0] KIND_PUSH_TOP    = 3'd0;
   localparam logic [2:0] KIND_PUSH_BOTTOM = 3'd1;
   localparam logic [2:0] KIND_POP_TOP     = 3'd2;
   localparam logic [2:0] KIND_POP_BOTTOM  = 3'd3;
   localparam logic [2:0] KIND_PEEK        = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;    // latch the accepted request
      logic update;     // apply push/pop, issue pop read
      logic latch_pop;  // take popped word from read port
      logic read_ends;  // read top and bottom words
      logic load;       // fill the result register
   } dq_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pop_ok;     // current request is a pop that will succeed
   } dq_stat_type;

   // one result transaction
   typedef struct packed {
      logic signed [31:0] popped_value;
      logic signed [31:0] top_value;
      logic signed [31:0] bottom_value;
      logic [4:0]         entry_count;
      logic               is_empty;
      logic [1:0]         status;
   } dq_rsp_type;

endpackage

@@ sv/dq_if.sv @@
// request channel
interface dq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [31:0] push_value;

   modport source (output valid, output kind, output push_value, input ready);
   modport sink   (input valid, input kind, input push_value, output ready);
endinterface

// result channel
interface dq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] popped_value;
   logic signed [31:0] top_value;
   logic signed [31:0] bottom_value;
   logic [4:0]         entry_count;
   logic               is_empty;
   logic [1:0]         status;

   modport source (output valid, output popped_value, output top_value,
                   output bottom_value, output entry_count, output is_empty,
                   output status, input ready);
   modport sink   (input valid, input popped_value, input top_value,
                   input bottom_value, input entry_count, input is_empty,
                   input status, output ready);
endinterface

@@ sv/dq_ctrl.sv @@
module dq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dq_pkg::dq_stat_type stat,
   output dq_pkg::dq_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_POP_LATCH,
      S_READ,
      S_LOAD,
      S_RESPOND
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               req_ready_ff <= 1'b1;
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  state_ff     <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               state_ff <= stat.pop_ok ? S_POP_LATCH : S_READ;
            end
            S_POP_LATCH: begin
               state_ff <= S_READ;
            end
            S_READ: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESPOND;
            end
            S_RESPOND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // commands decoded from state
   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == S_IDLE) && req_valid && req_ready_ff;
      cmd.update    = (state_ff == S_UPDATE);
      cmd.latch_pop = (state_ff == S_POP_LATCH);
      cmd.read_ends = (state_ff == S_READ);
      cmd.load      = (state_ff == S_LOAD);
   end

endmodule

@@ sv/dq_datapath.sv @@
module dq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  dq_pkg::dq_cmd_type  cmd,
   output dq_pkg::dq_stat_type stat,
   input  logic [2:0]          req_kind,
   input  logic signed [31:0]  req_push_value,
   output dq_pkg::dq_rsp_type  rsp_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0]   DEPTH_W    = (IW + 1)'(DEPTH);
   localparam logic [IW-1:0] LAST_INDEX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // ring store, registered reads
   logic [31:0] mem [DEPTH];

   logic [2:0]         kind_ff;
   logic signed [31:0] value_ff;
   logic [IW-1:0]      bottom_ff, bottom_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [1:0]         status_ff, status_in;
   logic [31:0]        popped_ff;
   logic [31:0]        rd_a_ff, rd_b_ff;
   dq_pkg::dq_rsp_type rsp_ff;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [IW-1:0]      rd_addr_a;
   logic [IW-1:0]      top_addr;
   logic [IW-1:0]      push_top_addr;
   logic [IW-1:0]      bottom_dec;
   logic [IW-1:0]      bottom_inc;
   logic [CW-1:0]      top_off;
   logic               empty;
   logic               full;

   // reduce a sum below twice the depth into a ring index
   function automatic logic [IW-1:0] ring_wrap(input logic [IW:0] sum);
      logic [IW:0] folded;
      folded = (sum >= DEPTH_W) ? (sum - DEPTH_W) : sum;
      return folded[IW-1:0];
   endfunction

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_COUNT);
   assign top_off = empty ? '0 : (count_ff - CW'(1));

   assign top_addr      = ring_wrap({1'b0, bottom_ff} + (IW + 1)'(top_off));
   assign push_top_addr = ring_wrap({1'b0, bottom_ff} + (IW + 1)'(count_ff));
   assign bottom_dec    = (bottom_ff == '0) ? LAST_INDEX : (bottom_ff - IW'(1));
   assign bottom_inc    = (bottom_ff == LAST_INDEX) ? '0 : (bottom_ff + IW'(1));

   assign stat.pop_ok = ((kind_ff == dq_pkg::KIND_POP_TOP) ||
                         (kind_ff == dq_pkg::KIND_POP_BOTTOM)) && !empty;

   // request decode and index update
   always_comb begin
      bottom_in = bottom_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = push_top_addr;
      rd_addr_a = top_addr;
      if (cmd.update) begin
         status_in = dq_pkg::STATUS_OK;
         case (kind_ff)
            dq_pkg::KIND_PUSH_TOP: begin
               if (full) begin
                  status_in = dq_pkg::STATUS_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = push_top_addr;
                  count_in = count_ff + CW'(1);
               end
            end
            dq_pkg::KIND_PUSH_BOTTOM: begin
               if (full) begin
                  status_in = dq_pkg::STATUS_PUSH_FULL;
               end else begin
                  wr_en     = 1'b1;
                  wr_addr   = bottom_dec;
                  bottom_in = bottom_dec;
                  count_in  = count_ff + CW'(1);
               end
            end
            dq_pkg::KIND_POP_TOP: begin
               if (empty) begin
                  status_in = dq_pkg::STATUS_POP_EMPTY;
               end else begin
                  rd_addr_a = top_addr;
                  count_in  = count_ff - CW'(1);
               end
            end
            dq_pkg::KIND_POP_BOTTOM: begin
               if (empty) begin
                  status_in = dq_pkg::STATUS_POP_EMPTY;
               end else begin
                  rd_addr_a = bottom_ff;
                  bottom_in = bottom_inc;
                  count_in  = count_ff - CW'(1);
               end
            end
            default: begin
               // peek and unused codes leave the deque alone
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff <= '0;
         count_ff  <= '0;
      end else begin
         bottom_ff <= bottom_in;
         count_ff  <= count_in;
      end
   end

   // request and working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         value_ff <= req_push_value;
      end
      status_ff <= status_in;
      if (cmd.update) begin
         popped_ff <= '0;
      end else if (cmd.latch_pop) begin
         popped_ff <= rd_a_ff;
      end
   end

   // store write port and two read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.update || cmd.read_ends) begin
         rd_a_ff <= mem[rd_addr_a];
      end
      if (cmd.read_ends) begin
         rd_b_ff <= mem[bottom_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.popped_value <= popped_ff;
         rsp_ff.top_value    <= empty ? '0 : rd_a_ff;
         rsp_ff.bottom_value <= empty ? '0 : rd_b_ff;
         rsp_ff.entry_count  <= 5'(count_ff);
         rsp_ff.is_empty     <= empty;
         rsp_ff.status       <= status_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ sv/double_ended_queue_unit.sv @@
// Channel    Direction  Handshake      Payload
// req_chan   in         valid/ready    kind, push_value
// rsp_chan   out        valid/ready    popped_value, top_value, bottom_value,
//                                      entry_count, is_empty, status
//
// One transaction at a time. rsp valid rises after a taken request passes the
// update, pop latch (successful pop only), read and load states; a new request
// is taken the cycle after the result leaves. These steps follow from the ring
// store's single write port and registered reads: update, latch a popped word,
// read top and bottom, then load the result register.
// Synchronous reset clears the indices and count; the store itself is not cleared.
// A stalled result holds its payload until rsp ready.
module double_ended_queue_unit #(
   parameter int DEPTH = 16
) (
   input logic     clock,
   input logic     reset,
   dq_req_if.sink  req_chan,
   dq_rsp_if.source rsp_chan
);

   dq_pkg::dq_cmd_type  cmd;
   dq_pkg::dq_stat_type stat;
   dq_pkg::dq_rsp_type  rsp_data;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_chan.kind),
      .req_push_value (req_chan.push_value),
      .rsp_data       (rsp_data)
   );

   // result payload onto the channel
   assign rsp_chan.popped_value = rsp_data.popped_value;
   assign rsp_chan.top_value    = rsp_data.top_value;
   assign rsp_chan.bottom_value = rsp_data.bottom_value;
   assign rsp_chan.entry_count  = rsp_data.entry_count;
   assign rsp_chan.is_empty     = rsp_data.is_empty;
   assign rsp_chan.status       = rsp_data.status;

endmodule

@@ sv/dq_checker.sv @@
module dq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [31:0] popped_value,
   input logic signed [31:0] top_value,
   input logic signed [31:0] bottom_value,
   input logic [4:0]        entry_count,
   input logic              is_empty,
   input logic [1:0]        status
);

   // a pending result stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   // no new request while a result is still pending
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken while a result is pending");

   // an empty deque reports zero count and zero end words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_empty |->
         (entry_count == 5'd0) && (top_value == 32'sd0) && (bottom_value == 32'sd0))
      else $error("empty result with non-zero contents");

   // a rejected pop leaves an empty deque and pops nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == dq_pkg::STATUS_POP_EMPTY) |->
         is_empty && (popped_value == 32'sd0))
      else $error("pop on empty rejected with data");

   // only defined status codes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status == dq_pkg::STATUS_OK) ||
                    (status == dq_pkg::STATUS_POP_EMPTY) ||
                    (status == dq_pkg::STATUS_PUSH_FULL))
      else $error("undefined status code");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .popped_value (rsp_chan.popped_value),
   .top_value    (rsp_chan.top_value),
   .bottom_value (rsp_chan.bottom_value),
   .entry_count  (rsp_chan.entry_count),
   .is_empty     (rsp_chan.is_empty),
   .status       (rsp_chan.status)
);
